>>> src/base64_encoder_unit_defines.svh
// Assertion macros shared by the checking code of the base64 encoder.
`ifndef BASE64_ENCODER_UNIT_DEFINES_SVH
`define BASE64_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B64E_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define B64E_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/b64enc_pkg.sv
`default_nettype none

package b64enc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // One group of three bytes, zero-filled when short.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [2:0] nalpha;  // alphabet characters in the group, 2 to 4
    logic       fin;     // group closes the message
  } group_t;

  // Map a sextet onto the standard alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/b64enc_front.sv
`default_nettype none

module b64enc_front
  import b64enc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  output logic            q_push,
  output group_t          q_entry
);

  logic [7:0] pend_b0;
  logic [7:0] pend_b1;
  logic [1:0] pend_cnt;
  logic       emit;

  // Emit a group on the final byte or on the byte that completes three.
  assign emit   = final_byte || (pend_cnt == 2'd2);
  assign q_push = accept && emit;

  always_comb begin
    q_entry.b0     = (pend_cnt == 2'd0) ? data_byte : pend_b0;
    q_entry.b1     = (pend_cnt == 2'd0) ? 8'd0 :
                     (pend_cnt == 2'd1) ? data_byte : pend_b1;
    q_entry.b2     = (pend_cnt == 2'd2) ? data_byte : 8'd0;
    q_entry.nalpha = {1'b0, pend_cnt} + 3'd2;
    q_entry.fin    = final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else if (accept) begin
      pend_cnt <= emit ? 2'd0 : pend_cnt + 2'd1;
    end
  end

  // Hold pending bytes.
  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      if (pend_cnt == 2'd0) begin
        pend_b0 <= data_byte;
      end else begin
        pend_b1 <= data_byte;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/b64enc_queue.sv
`default_nettype none

module b64enc_queue
  import b64enc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire group_t wr_data,
  input  wire logic   rd_en,
  output group_t      rd_data,
  output logic        q_full,
  output logic        q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> src/b64enc_back.sv
`default_nettype none

module b64enc_back
  import b64enc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire group_t     q_entry,
  output logic            q_pop,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      text_char,
  output logic            run_end,
  output logic            text_end
);

  group_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       out_valid;
  logic       load_out;
  logic       last_slot;
  logic [5:0] sextet;
  logic [7:0] char_next;

  assign empty     = !out_valid;
  assign load_out  = cur_valid && (!out_valid || pop);
  assign last_slot = (idx == 2'd3);
  assign q_pop     = !q_empty && (!cur_valid || (load_out && last_slot));

  always_comb begin
    case (idx)
      2'd0:    sextet = cur.b0[7:2];
      2'd1:    sextet = {cur.b0[1:0], cur.b1[7:4]};
      2'd2:    sextet = {cur.b1[3:0], cur.b2[7:6]};
      default: sextet = cur.b2[5:0];
    endcase
    char_next = ({1'b0, idx} >= cur.nalpha) ? PAD_CHAR : sextet_char(sextet);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (load_out && last_slot) begin
        cur_valid <= 1'b0;
      end
      if (load_out) begin
        idx <= idx + 2'd1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
    if (load_out) begin
      text_char <= char_next;
      run_end   <= last_slot;
      text_end  <= last_slot && cur.fin;
    end
  end

endmodule

`default_nettype wire

>>> src/base64_encoder_unit.sv
// Base64 encoder, standard alphabet with '=' padding, one byte per transaction.
// Path: group queue, then current-group register, then character output register.
// Throughput: one byte per cycle in while the queue has room; one character per cycle out
//   while the output is popped, so a steady stream is set by four characters per group.
// Reset: synchronous, clears pending count, queue pointers and all valid flags.
`default_nettype none

`include "base64_encoder_unit_defines.svh"

module base64_encoder_unit
  import b64enc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      text_char,
  output logic            run_end,
  output logic            text_end
);

  // Queue between the front (byte gathering) and the back (character output).
  logic   accept;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  group_t q_wr_entry;
  group_t q_rd_entry;

  // Take a transaction whenever the group queue has room; hold off every byte
  // while the queue is full, even one that would only be gathered.
  assign full   = q_full;
  assign accept = push && !full;

  // Front: hold up to two bytes, build a zero-filled group on the third byte
  // or on the final byte.
  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_push     (q_push),
    .q_entry    (q_wr_entry)
  );

  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_entry),
    .rd_en   (q_pop),
    .rd_data (q_rd_entry),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Back: step through four character slots per group, padding the tail,
  // and present each character from an output register.
  b64enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (q_rd_entry),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .text_char (text_char),
    .run_end   (run_end),
    .text_end  (text_end)
  );

  // The end of the text always closes a group.
  `B64E_ASSERT_IMP(a_text_end_closes_run, !empty && text_end, run_end,
                   "text_end without run_end")
  // A final byte must always produce a group.
  `B64E_ASSERT_IMP(a_final_emits_group, accept && final_byte, q_push,
                   "final byte did not push a group")
  // The back never drains an empty queue.
  `B64E_ASSERT_IMP(a_no_pop_on_empty, q_pop, !q_empty,
                   "group queue read while empty")

endmodule

`default_nettype wire
